FILE: hw/rtl/fat12_cluster_chain_walker_top_macros.svh
// Assertion helpers for the checker file of the chain walker.
// Each macro takes a label, the clock, the reset, the two sides of the
// implication and a message string.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_MACROS_SVH

// Same-cycle implication
`define FCW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define FCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fcw_pkg.sv
// ----------------------------------------------------------------------------
// fcw_pkg
// Types and constants shared by the FAT12 cluster chain walker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcw_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_OPEN    = 2'd1;
   localparam logic [1:0] FUNC_ADVANCE = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_DATA_START = 2'd0;
   localparam logic [1:0] CSR_SPC        = 2'd1;

   // FAT12 constants
   localparam logic [11:0] ENTRY_MASK       = 12'hFFF;
   localparam logic [11:0] END_MARK         = 12'hFF8;
   localparam int          BYTES_PER_SECTOR = 512;
   localparam logic [7:0]  MAX_SPC          = 8'd128;
   localparam int          OFF_W            = 13;

   typedef struct packed {
      logic [1:0]  func;
      logic [12:0] fat_address;
      logic [7:0]  fat_byte;
      logic        linear;
      logic [11:0] first_cluster;
      logic [31:0] start_lba;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] lba;
      logic        end_of_chain;
      logic [11:0] cluster;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_NEXT,
      ST_PRODUCT,
      ST_EMIT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic apply;       // take the request at the port
      logic reduce;      // subtract the store size from the table offset
      logic mem_read;    // read both table bytes
      logic take_next;   // load the next cluster from the read bytes
      logic product;     // register the cluster offset times sector count product
      logic emit;        // load the response register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       wrap;      // an advance here needs a table lookup
      logic       off_low;   // table offset is inside the store
      logic       rsp_free;  // response register can take a new response
   } dp_status_type;

   // FAT12 packs each entry into one and a half bytes
   function automatic logic [11:0] entry_select(input logic [15:0] word, input logic odd);
      logic [11:0] ent;
      ent = odd ? word[15:4] : (word[11:0] & ENTRY_MASK);
      return ent;
   endfunction

endpackage

FILE: hw/rtl/fat12_cluster_chain_walker_top.sv
// A load request leaves the walker idle. An open, a linear advance, an
// advance on an ended chain and an advance that stays in its cluster pass
// through request, product register and response load before the next
// acceptance. An advance that leaves its cluster first reduces the table
// offset into the store, one subtraction per cycle (none while the store
// holds at least 6144 bytes), then both table bytes come from one registered
// read of the FAT store and the next cluster is registered before the LBA
// product. A response waiting in the output register does not block
// acceptance; only the response load waits for it.
// Configuration writes are taken in any cycle but belong in idle time.
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top
// FAT12 cluster chain walker: holds a FAT table and gives the LBA of each
// sector of a file, in chain or linear mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_top
   import fcw_pkg::*;
#(
   parameter int FAT_BYTES = 8192
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer
   fcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   fcw_datapath #(
      .FAT_BYTES (FAT_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

FILE: hw/rtl/fcw_ctrl.sv
// ----------------------------------------------------------------------------
// fcw_ctrl
// Sequencer for the chain walker: takes requests, steps the table lookup,
// the LBA product and the response load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcw_ctrl
   import fcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (status.func)
                  FUNC_OPEN:    state_in = ST_PRODUCT;
                  FUNC_ADVANCE: state_in = status.wrap ? ST_REDUCE : ST_PRODUCT;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_REDUCE: begin
            if (status.off_low) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT:    state_in = ST_PRODUCT;
         ST_PRODUCT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.apply = req_valid;
         end
         ST_REDUCE: begin
            cmd.reduce   = !status.off_low;
            cmd.mem_read = status.off_low;
         end
         ST_NEXT:    cmd.take_next = 1'b1;
         ST_PRODUCT: cmd.product   = 1'b1;
         ST_EMIT:    cmd.emit      = status.rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/fcw_datapath.sv
// ----------------------------------------------------------------------------
// fcw_datapath
// Walker state, configuration registers, FAT byte store, LBA arithmetic and
// the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcw_datapath
   import fcw_pkg::*;
#(
   parameter int FAT_BYTES = 8192
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_wdata,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   status
);

   localparam int ADDR_W = $clog2(FAT_BYTES);

   logic [7:0]       fat_mem [FAT_BYTES];
   logic [7:0]       rd_lo_ff, rd_hi_ff;

   logic [31:0]      data_start_ff, data_start_in;
   logic [7:0]       spc_ff, spc_in;
   logic [31:0]      position_ff, position_in;
   logic [6:0]       sector_ff, sector_in;
   logic             linear_ff, linear_in;
   logic             ended_ff, ended_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [31:0]      product_ff, product_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic [7:0]        spc_eff;
   logic [7:0]        sector_next;
   logic              wrap;
   logic [ADDR_W-1:0] rd_addr0, rd_addr1;
   logic [39:0]       product_full;
   logic [11:0]       next_cluster;
   logic [11:0]       cur_cluster;
   logic              load_hit;

   // Clamp the sector count to 1..128
   always_comb begin
      if (spc_ff == 8'd0) begin
         spc_eff = 8'd1;
      end else if (spc_ff > MAX_SPC) begin
         spc_eff = MAX_SPC;
      end else begin
         spc_eff = spc_ff;
      end
   end

   assign cur_cluster = position_ff[11:0];
   assign sector_next = {1'b0, sector_ff} + 8'd1;
   assign wrap        = !linear_ff && !ended_ff && (sector_next >= spc_eff);

   assign status.func     = req_payload.func;
   assign status.wrap     = wrap;
   assign status.off_low  = 32'(off_ff) < FAT_BYTES;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   // Table byte addresses, second byte wraps to the store start
   assign rd_addr0 = off_ff[ADDR_W-1:0];
   assign rd_addr1 = (32'(off_ff) == FAT_BYTES - 1) ? '0 : (off_ff[ADDR_W-1:0] + 1'b1);

   assign load_hit = cmd.apply && (req_payload.func == FUNC_LOAD)
                     && (32'(req_payload.fat_address) < FAT_BYTES);

   // FAT store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (load_hit) begin
         fat_mem[req_payload.fat_address[ADDR_W-1:0]] <= req_payload.fat_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_lo_ff <= fat_mem[rd_addr0];
         rd_hi_ff <= fat_mem[rd_addr1];
      end
   end

   assign next_cluster = entry_select({rd_hi_ff, rd_lo_ff}, cur_cluster[0]);

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      data_start_in = data_start_ff;
      spc_in        = spc_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DATA_START: data_start_in = csr_wdata;
            CSR_SPC:        spc_in        = csr_wdata[7:0];
            default: begin
               data_start_in = data_start_ff;
            end
         endcase
      end
   end

   // Walker state update
   always_comb begin
      position_in = position_ff;
      sector_in   = sector_ff;
      linear_in   = linear_ff;
      ended_in    = ended_ff;
      off_in      = off_ff;
      if (cmd.apply) begin
         case (req_payload.func)
            FUNC_OPEN: begin
               linear_in = req_payload.linear;
               sector_in = '0;
               if (req_payload.linear) begin
                  position_in = req_payload.start_lba;
                  ended_in    = 1'b0;
               end else begin
                  position_in = {20'd0, req_payload.first_cluster};
                  ended_in    = req_payload.first_cluster >= END_MARK;
               end
            end
            FUNC_ADVANCE: begin
               if (linear_ff) begin
                  position_in = position_ff + 32'd1;
               end else if (!ended_ff) begin
                  if (wrap) begin
                     sector_in = '0;
                     off_in    = OFF_W'(cur_cluster) + OFF_W'(cur_cluster[11:1]);
                  end else begin
                     sector_in = sector_next[6:0];
                  end
               end
            end
            default: begin
               position_in = position_ff;
            end
         endcase
      end
      if (cmd.reduce) begin
         off_in = OFF_W'(32'(off_ff) - FAT_BYTES);
      end
      if (cmd.take_next) begin
         position_in = {20'd0, next_cluster};
         ended_in    = next_cluster >= END_MARK;
      end
   end

   // Cluster offset times sector count
   assign product_full = (position_ff - 32'd2) * {32'd0, spc_eff};
   assign product_in   = cmd.product ? product_full[31:0] : product_ff;

   // Response register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_in.cluster = cur_cluster;
         if (linear_ff) begin
            rsp_in.lba          = position_ff;
            rsp_in.end_of_chain = 1'b0;
         end else if (ended_ff) begin
            rsp_in.lba          = '0;
            rsp_in.end_of_chain = 1'b1;
         end else begin
            rsp_in.lba          = data_start_ff + product_ff + {25'd0, sector_ff};
            rsp_in.end_of_chain = 1'b0;
         end
      end
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff <= '0;
         spc_ff        <= 8'd1;
         position_ff   <= '0;
         sector_ff     <= '0;
         linear_ff     <= 1'b0;
         ended_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         data_start_ff <= data_start_in;
         spc_ff        <= spc_in;
         position_ff   <= position_in;
         sector_ff     <= sector_in;
         linear_ff     <= linear_in;
         ended_ff      <= ended_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      product_ff <= product_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/fcw_checker.sv
// ----------------------------------------------------------------------------
// fcw_checker
// Port-level checks of the chain walker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fat12_cluster_chain_walker_top_macros.svh"

module fcw_checker
   import fcw_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // Hold a stalled response
   `FCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled response dropped or changed")

   // Open request keeps the walker busy the next cycle
   `FCW_ASSERT_NEXT(a_open_busy, clock, reset, req_valid && !req_stall && (req_payload.func == FUNC_OPEN), req_stall, "open request did not occupy the walker")

   // End of chain gives a zero LBA
   `FCW_ASSERT_SAME(a_end_lba, clock, reset, rsp_valid && rsp_payload.end_of_chain, rsp_payload.lba == 32'd0, "end of chain with nonzero LBA")

   // End of chain carries an end marker cluster
   `FCW_ASSERT_SAME(a_end_cluster, clock, reset, rsp_valid && rsp_payload.end_of_chain, rsp_payload.cluster >= END_MARK, "end of chain below end marker")

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (.*);

FILE: tb/fat12_cluster_chain_walker_top_tb.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top_tb
// Self-checking bench for the FAT12 chain walker. A directed table covers
// reset state, field extremes, end of chain and cluster numbers below two.
// Random phases then load chains, open them and advance through them under
// several register settings and idle/stall profiles. A predictor tracks the
// table and the walk and checks every sector address that comes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_top_tb;
   import fcw_pkg::*;

   localparam int FAT_STORE_BYTES = 8192;
   localparam int SETTLE_CYCLES   = 16;
   localparam int RUN_LIMIT       = 400000;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_REQUESTS  = 90;

   typedef struct {
      req_payload_type req;
      bit              typed;
      rsp_payload_type rsp;
   } walk_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = CSR_DATA_START;
   logic [31:0]     csr_wdata = '0;

   // Predictor state: table copy, walk position and register settings
   bit [7:0]    fat_mem [FAT_STORE_BYTES];
   bit          fat_written [FAT_STORE_BYTES];
   logic [31:0] walk_pos = '0;
   logic [6:0]  walk_sector = '0;
   logic        walk_linear = 1'b0;
   logic        walk_ended = 1'b0;
   logic [31:0] cfg_data_start = '0;
   logic [7:0]  cfg_spc = 8'd1;

   rsp_payload_type pending_sectors [$];
   walk_row_type    dir_rows [$];

   // Handshake flags sampled at the falling edge, used at the next rising edge
   bit              req_take = 1'b0;
   bit              csr_take = 1'b0;
   bit              row_typed = 1'b0;
   rsp_payload_type row_rsp = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int requests_sent = 0;
   int requests_taken = 0;
   int sectors_checked = 0;
   int chain_ends_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   fat12_cluster_chain_walker_top #(
      .FAT_BYTES(FAT_STORE_BYTES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Stall the response side at the phase rate
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Out-of-range sector counts act as the nearest legal one
   function automatic logic [7:0] clamp_spc(input logic [7:0] s);
      if (s == 8'd0) return 8'd1;
      if (s > MAX_SPC) return MAX_SPC;
      return s;
   endfunction

   function automatic int table_offset(input logic [11:0] c);
      return (int'(c) * 3 / 2) % FAT_STORE_BYTES;
   endfunction

   // Unpack the 12-bit entry of cluster c from its two table bytes
   function automatic logic [11:0] next_cluster(input logic [11:0] c);
      int          off;
      logic [15:0] w;
      off = table_offset(c);
      w = {fat_mem[(off + 1) % FAT_STORE_BYTES], fat_mem[off]};
      return c[0] ? w[15:4] : w[11:0];
   endfunction

   function automatic rsp_payload_type sector_report();
      rsp_payload_type r;
      r.cluster = walk_pos[11:0];
      r.end_of_chain = 1'b0;
      if (walk_linear) begin
         r.lba = walk_pos;
      end else if (walk_ended) begin
         r.lba = '0;
         r.end_of_chain = 1'b1;
      end else begin
         r.lba = cfg_data_start + (walk_pos - 32'd2) * 32'(clamp_spc(cfg_spc))
                 + 32'(walk_sector);
      end
      return r;
   endfunction

   // Apply one request to the predictor; returns 1 when a sector report follows
   function automatic bit walk_step(input req_payload_type req,
                                    output rsp_payload_type r);
      int next_idx;
      bit has;
      has = 1'b0;
      r = '0;
      case (req.func)
         FUNC_LOAD: begin
            if (int'(req.fat_address) < FAT_STORE_BYTES) begin
               fat_mem[req.fat_address] = req.fat_byte;
               fat_written[req.fat_address] = 1'b1;
            end
         end
         FUNC_OPEN: begin
            walk_linear = req.linear;
            walk_sector = '0;
            if (req.linear) begin
               walk_pos = req.start_lba;
               walk_ended = 1'b0;
            end else begin
               walk_pos = {20'd0, req.first_cluster};
               walk_ended = (walk_pos >= 32'(END_MARK));
            end
            has = 1'b1;
         end
         FUNC_ADVANCE: begin
            if (walk_linear) begin
               walk_pos = walk_pos + 32'd1;
            end else if (!walk_ended) begin
               next_idx = int'(walk_sector) + 1;
               if (next_idx >= int'(clamp_spc(cfg_spc))) begin
                  walk_sector = '0;
                  walk_pos = {20'd0, next_cluster(walk_pos[11:0])};
               end else begin
                  walk_sector = 7'(next_idx);
               end
               if (walk_pos >= 32'(END_MARK)) walk_ended = 1'b1;
            end
            has = 1'b1;
         end
         default: has = 1'b0;
      endcase
      if (has) r = sector_report();
      return has;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: sample handshakes at the falling edge, check and predict
   // ------------------------------------------------------------------
   always @(negedge clock) begin : monitor
      rsp_payload_type predicted;
      rsp_payload_type wanted;
      bit              has;
      req_take = !reset && req_valid && !req_stall;
      csr_take = !reset && csr_valid && csr_ready;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sectors.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected sector report lba %h end %b cluster %h", $time,
                     rsp_payload.lba, rsp_payload.end_of_chain, rsp_payload.cluster);
         end else begin
            wanted = pending_sectors.pop_front();
            sectors_checked++;
            if (wanted.end_of_chain) chain_ends_checked++;
            if (rsp_payload.lba !== wanted.lba) begin
               mismatches++;
               $display("%0t: lba expected %h actual %h", $time,
                        wanted.lba, rsp_payload.lba);
            end
            if (rsp_payload.end_of_chain !== wanted.end_of_chain) begin
               mismatches++;
               $display("%0t: end_of_chain expected %b actual %b", $time,
                        wanted.end_of_chain, rsp_payload.end_of_chain);
            end
            if (rsp_payload.cluster !== wanted.cluster) begin
               mismatches++;
               $display("%0t: cluster expected %h actual %h", $time,
                        wanted.cluster, rsp_payload.cluster);
            end
         end
      end
      if (csr_take) begin
         case (csr_index)
            CSR_DATA_START: cfg_data_start = csr_wdata;
            CSR_SPC:        cfg_spc = csr_wdata[7:0];
            default: ;
         endcase
      end
      if (req_take) begin
         requests_taken++;
         has = walk_step(req_payload, predicted);
         if (has) pending_sectors.push_back(row_typed ? row_rsp : predicted);
      end
   end

   // ------------------------------------------------------------------
   // Request driving
   // ------------------------------------------------------------------

   // Hold one request until it is taken, after a random idle gap
   task automatic send_request(input req_payload_type req, input bit typed,
                               input rsp_payload_type rsp);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= req;
      row_typed = typed;
      row_rsp = rsp;
      do @(posedge clock); while (!req_take);
      if (req.func != FUNC_UNUSED) requests_sent++;
   endtask

   function automatic req_payload_type random_fields();
      req_payload_type r;
      r.func = 2'($urandom);
      r.fat_address = 13'($urandom);
      r.fat_byte = 8'($urandom);
      r.linear = 1'($urandom);
      r.first_cluster = 12'($urandom);
      r.start_lba = $urandom;
      return r;
   endfunction

   function automatic req_payload_type make_req(input logic [1:0] func,
                                                input logic [12:0] addr,
                                                input logic [7:0] data,
                                                input logic lin,
                                                input logic [11:0] clus,
                                                input logic [31:0] start);
      req_payload_type r;
      r.func = func;
      r.fat_address = addr;
      r.fat_byte = data;
      r.linear = lin;
      r.first_cluster = clus;
      r.start_lba = start;
      return r;
   endfunction

   function automatic rsp_payload_type sector(input logic [31:0] lba, input logic eoc,
                                              input logic [11:0] clus);
      rsp_payload_type r;
      r.lba = lba;
      r.end_of_chain = eoc;
      r.cluster = clus;
      return r;
   endfunction

   task automatic add_row(input req_payload_type req, input bit typed,
                          input rsp_payload_type rsp);
      walk_row_type row;
      row.req = req;
      row.typed = typed;
      row.rsp = rsp;
      dir_rows.push_back(row);
   endtask

   task automatic send_load(input logic [12:0] addr, input logic [7:0] data);
      req_payload_type req;
      req = random_fields();
      req.func = FUNC_LOAD;
      req.fat_address = addr;
      req.fat_byte = data;
      send_request(req, 1'b0, '0);
   endtask

   task automatic send_open(input logic lin, input logic [11:0] clus,
                            input logic [31:0] start);
      req_payload_type req;
      req = random_fields();
      req.func = FUNC_OPEN;
      req.linear = lin;
      req.first_cluster = clus;
      req.start_lba = start;
      send_request(req, 1'b0, '0);
   endtask

   // Load the entry first when this advance would read a byte never written
   task automatic send_advance();
      req_payload_type req;
      int              off;
      if (!walk_linear && !walk_ended &&
          int'(walk_sector) + 1 >= int'(clamp_spc(cfg_spc))) begin
         off = table_offset(walk_pos[11:0]);
         if (!fat_written[off]) send_load(13'(off), 8'($urandom));
         if (!fat_written[(off + 1) % FAT_STORE_BYTES])
            send_load(13'((off + 1) % FAT_STORE_BYTES), 8'($urandom));
      end
      req = random_fields();
      req.func = FUNC_ADVANCE;
      send_request(req, 1'b0, '0);
   endtask

   // Point the entry of cluster c at nxt, keeping the neighbor's nibble
   task automatic link_entry(input logic [11:0] c, input logic [11:0] nxt);
      int          off;
      logic [15:0] w;
      off = table_offset(c);
      w = {fat_mem[(off + 1) % FAT_STORE_BYTES], fat_mem[off]};
      if (c[0]) w = {nxt, w[3:0]};
      else w = {w[15:12], nxt};
      send_load(13'(off), w[7:0]);
      send_load(13'((off + 1) % FAT_STORE_BYTES), w[15:8]);
   endtask

   // Build a short chain ending in an end marker, open it and walk it
   task automatic walk_chain_sequence();
      logic [11:0] links [0:4];
      int          len;
      int          span;
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
         links[i] = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 3))
                                                : 12'($urandom_range(2, 12'hFF7));
      end
      for (int i = 0; i < len; i++) begin
         link_entry(links[i], (i == len - 1) ? 12'($urandom_range(12'hFF8, 12'hFFF))
                                             : links[i + 1]);
      end
      send_open(1'b0, links[0], $urandom);
      span = len * int'(clamp_spc(cfg_spc)) + 2;
      if (span > 200) span = 200;
      repeat ($urandom_range(1, span)) send_advance();
   endtask

   task automatic walk_linear_sequence();
      logic [31:0] start;
      start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8)
                                          : $urandom;
      send_open(1'b1, 12'($urandom), start);
      repeat ($urandom_range(1, 12)) send_advance();
   endtask

   task automatic send_noise();
      req_payload_type req;
      case ($urandom_range(0, 3))
         0: send_load(13'($urandom), 8'($urandom));
         1: send_open(1'($urandom), 12'($urandom), $urandom);
         2: send_advance();
         default: begin
            req = random_fields();
            req.func = FUNC_UNUSED;
            send_request(req, 1'b0, '0);
         end
      endcase
   endtask

   // Drop valid and hold off until every sector report is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_sectors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] data_start, input logic [7:0] spc);
      csr_valid <= 1'b1;
      csr_index <= CSR_DATA_START;
      csr_wdata <= data_start;
      do @(posedge clock); while (!csr_take);
      csr_index <= CSR_SPC;
      csr_wdata <= {24'd0, spc};
      do @(posedge clock); while (!csr_take);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      logic [31:0] data_start;
      logic [7:0]  spc;
      int          phase_base;
      int          r;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table, run with the reset register values
      add_row(make_req(FUNC_OPEN, 13'h1FFF, 8'hFF, 1'b1, 12'hFFF, 32'hFFFF_FFFF), 1'b1,
              sector(32'hFFFF_FFFF, 1'b0, 12'hFFF));
      add_row(make_req(FUNC_ADVANCE, 13'h0000, 8'h00, 1'b0, 12'h000, 32'h0), 1'b1,
              sector(32'h0, 1'b0, 12'h000));
      add_row(make_req(FUNC_LOAD, 13'h1FFF, 8'hFF, 1'b1, 12'hFFF, 32'hFFFF_FFFF), 1'b0, '0);
      add_row(make_req(FUNC_LOAD, 13'h0000, 8'h00, 1'b0, 12'h000, 32'h0), 1'b0, '0);
      // cluster 2 -> 3 -> end marker, cluster 0xFF7 -> 2
      add_row(make_req(FUNC_LOAD, 13'd3, 8'h03, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_LOAD, 13'd4, 8'hF0, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_LOAD, 13'd5, 8'hFF, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_LOAD, 13'd6130, 8'h2A, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_LOAD, 13'd6131, 8'h00, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_OPEN, 13'h0, 8'h0, 1'b0, 12'd2, 32'h0), 1'b1,
              sector(32'h0, 1'b0, 12'd2));
      add_row(make_req(FUNC_ADVANCE, 13'h0, 8'h0, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_ADVANCE, 13'h0, 8'h0, 1'b0, 12'h0, 32'h0), 1'b1,
              sector(32'h0, 1'b1, 12'hFFF));
      add_row(make_req(FUNC_ADVANCE, 13'h0, 8'h0, 1'b0, 12'h0, 32'h0), 1'b1,
              sector(32'h0, 1'b1, 12'hFFF));
      add_row(make_req(FUNC_UNUSED, 13'h1555, 8'hAA, 1'b1, 12'hAAA, 32'h5555_AAAA), 1'b0, '0);
      add_row(make_req(FUNC_OPEN, 13'h0, 8'h0, 1'b0, 12'hFFF, 32'hFFFF_FFFF), 1'b1,
              sector(32'h0, 1'b1, 12'hFFF));
      add_row(make_req(FUNC_OPEN, 13'h0, 8'h0, 1'b0, END_MARK, 32'h0), 1'b1,
              sector(32'h0, 1'b1, END_MARK));
      add_row(make_req(FUNC_OPEN, 13'h0, 8'h0, 1'b0, 12'hFF7, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_ADVANCE, 13'h0, 8'h0, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      // cluster numbers below two wrap in the address product
      add_row(make_req(FUNC_OPEN, 13'h0, 8'h0, 1'b0, 12'd0, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_OPEN, 13'h0, 8'h0, 1'b0, 12'd1, 32'h0), 1'b0, '0);
      add_row(make_req(FUNC_OPEN, 13'h0, 8'h0, 1'b1, 12'hFFF, 32'h0), 1'b1,
              sector(32'h0, 1'b0, 12'h000));
      add_row(make_req(FUNC_ADVANCE, 13'h0, 8'h0, 1'b0, 12'h0, 32'h0), 1'b0, '0);
      foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      drain();

      // Random phases: new register setting and idle profile each time
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin data_start = 32'h0;         spc = 8'd1;   end
            1: begin data_start = 32'hFFFF_FFFF; spc = MAX_SPC; end
            2: begin data_start = $urandom;      spc = 8'd0;   end
            3: begin data_start = $urandom;      spc = 8'd255; end
            4: begin data_start = $urandom;      spc = 8'($urandom_range(2, 8)); end
            5: begin data_start = 32'h8000_0000; spc = 8'd3;   end
            6: begin data_start = $urandom;      spc = 8'($urandom_range(1, 255)); end
            default: begin data_start = $urandom; spc = 8'd1; end
         endcase
         set_config(data_start, spc);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         phase_base = requests_sent;
         while (requests_sent - phase_base < PHASE_REQUESTS) begin
            r = $urandom_range(0, 99);
            if (r < 60) walk_chain_sequence();
            else if (r < 75) walk_linear_sequence();
            else send_noise();
         end
         drain();
      end

      $display("Summary: %0d requests over %0d register settings, %0d sector reports checked",
               requests_taken, PHASE_COUNT + 1, sectors_checked);
      $display("Summary: %0d reports at end of chain, %0d mismatches",
               chain_ends_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: fat12_cluster_chain_walker_top.f
+incdir+hw/rtl
hw/rtl/fcw_pkg.sv
hw/rtl/fcw_ctrl.sv
hw/rtl/fcw_datapath.sv
hw/rtl/fat12_cluster_chain_walker_top.sv
hw/rtl/fcw_checker.sv
tb/fat12_cluster_chain_walker_top_tb.sv
